/* rtl/spd_pkg.sv */
// Shared constants and types of the strict priority request dispatcher.
package spd_pkg;

   localparam int LEVEL_DEPTH_DEF = 16;
   localparam int NUM_LEVELS_DEF  = 3;
   localparam int WORD_W          = 32;
   localparam int PRIO_W          = 2;
   localparam int WAITING_W       = 6;

   localparam logic OP_REQUEST  = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   typedef enum logic [1:0] {
      KIND_DISPATCH = 2'd0,
      KIND_RESPONSE = 2'd1,
      KIND_REJECT   = 2'd2
   } kind_type;

   typedef struct packed {
      logic                     op;
      logic                     pool;
      logic [PRIO_W-1:0]        prio;
      logic [WORD_W-1:0]        vm_ident;
      logic [WORD_W-1:0]        req_ident;
      logic signed [WORD_W-1:0] operand_a;
      logic signed [WORD_W-1:0] operand_b;
      logic [WORD_W-1:0]        exec_result;
   } req_item_type;

   typedef struct packed {
      kind_type                 kind;
      logic [WORD_W-1:0]        out_vm;
      logic [WORD_W-1:0]        out_req;
      logic                     out_pool;
      logic [PRIO_W-1:0]        out_prio;
      logic signed [WORD_W-1:0] out_a;
      logic signed [WORD_W-1:0] out_b;
      logic [WORD_W-1:0]        out_value;
      logic [WAITING_W-1:0]     waiting;
      logic [WORD_W-1:0]        done_pool_a;
      logic [WORD_W-1:0]        done_pool_b;
      logic                     last;
   } rsp_item_type;

   typedef struct packed {
      logic [WORD_W-1:0]        vm;
      logic [WORD_W-1:0]        req;
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] b;
      logic                     pool;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic reject;
      logic enqueue;
      logic direct;
      logic respond;
      logic pop;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic op_complete;
      logic prio_ok;
      logic level_full;
      logic busy;
      logic any_waiting;
   } dp_status_type;

endpackage

/* rtl/spd_chan_if.sv */
// Valid/ready channel interface that carries one transaction payload.
interface spd_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/spd_ctrl.sv */
// Controller state machine that sequences capture, decision and result delivery.
module spd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  spd_pkg::dp_status_type status,
   output spd_pkg::ctrl_cmd_type  cmd
);
   import spd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_OUT_MID,
      ST_OUT_LAST
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture  = 1'b1;
               state_in     = ST_EXEC;
               req_ready_in = 1'b0;
            end
         end
         ST_EXEC: begin
            if (!status.op_complete) begin
               if (!status.prio_ok || status.level_full) begin
                  cmd.reject   = 1'b1;
                  state_in     = ST_OUT_LAST;
                  rsp_valid_in = 1'b1;
               end else if (status.busy) begin
                  cmd.enqueue  = 1'b1;
                  state_in     = ST_IDLE;
                  req_ready_in = 1'b1;
               end else begin
                  cmd.direct   = 1'b1;
                  state_in     = ST_OUT_LAST;
                  rsp_valid_in = 1'b1;
               end
            end else if (status.busy) begin
               cmd.respond  = 1'b1;
               cmd.pop      = status.any_waiting;
               state_in     = status.any_waiting ? ST_OUT_MID : ST_OUT_LAST;
               rsp_valid_in = 1'b1;
            end else begin
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
            end
         end
         ST_OUT_MID: begin
            if (rsp_ready) begin
               cmd.load = 1'b1;
               state_in = ST_OUT_LAST;
            end
         end
         ST_OUT_LAST: begin
            if (rsp_ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/spd_datapath.sv */
// Datapath with the level queues, entry store, executor slot and counters.
module spd_datapath #(
   parameter int LEVEL_DEPTH = spd_pkg::LEVEL_DEPTH_DEF,
   parameter int NUM_LEVELS  = spd_pkg::NUM_LEVELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spd_pkg::req_item_type  req_payload,
   input  spd_pkg::ctrl_cmd_type  cmd,
   output spd_pkg::dp_status_type status,
   output spd_pkg::rsp_item_type  rsp_payload
);
   import spd_pkg::*;

   localparam int DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TOT_W  = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   req_item_type      item_ff;
   entry_type         mem [DEPTH];
   entry_type         rd_ff;
   logic [PTR_W-1:0]  head_ff  [NUM_LEVELS];
   logic [PTR_W-1:0]  tail_ff  [NUM_LEVELS];
   logic [CNT_W-1:0]  count_ff [NUM_LEVELS];
   logic [TOT_W-1:0]  total_ff;
   logic              busy_ff;
   logic [WORD_W-1:0] cur_vm_ff;
   logic [WORD_W-1:0] cur_req_ff;
   logic              cur_pool_ff;
   logic [PRIO_W-1:0] cur_prio_ff;
   logic [WORD_W-1:0] done_a_ff;
   logic [WORD_W-1:0] done_b_ff;
   logic [LVL_W-1:0]  sel_lvl_ff;
   rsp_item_type      out_ff;

   logic [LVL_W-1:0]  in_lvl;
   logic [LVL_W-1:0]  top_lvl;
   logic              prio_ok;
   logic              any_waiting;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      top_lvl     = '0;
      any_waiting = 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (count_ff[l] != '0) begin
            top_lvl     = LVL_W'(l);
            any_waiting = 1'b1;
         end
      end
   end

   assign prio_ok = int'(item_ff.prio) < NUM_LEVELS;
   assign in_lvl  = LVL_W'(item_ff.prio);
   assign wr_addr = ADDR_W'(int'(in_lvl) * LEVEL_DEPTH + int'(tail_ff[in_lvl]));
   assign rd_addr = ADDR_W'(int'(top_lvl) * LEVEL_DEPTH + int'(head_ff[top_lvl]));

   assign status.op_complete = (item_ff.op == OP_COMPLETE);
   assign status.prio_ok     = prio_ok;
   assign status.level_full  = prio_ok && (count_ff[in_lvl] == CNT_W'(LEVEL_DEPTH));
   assign status.busy        = busy_ff;
   assign status.any_waiting = any_waiting;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      if (cmd.enqueue) begin
         mem[wr_addr] <= '{vm: item_ff.vm_ident, req: item_ff.req_ident,
                           a: item_ff.operand_a, b: item_ff.operand_b,
                           pool: item_ff.pool};
      end
      if (cmd.pop) begin
         rd_ff      <= mem[rd_addr];
         sel_lvl_ff <= top_lvl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
         total_ff    <= '0;
         busy_ff     <= 1'b0;
         cur_vm_ff   <= '0;
         cur_req_ff  <= '0;
         cur_pool_ff <= 1'b0;
         cur_prio_ff <= '0;
         done_a_ff   <= '0;
         done_b_ff   <= '0;
      end else begin
         if (cmd.enqueue) begin
            tail_ff[in_lvl]  <= advance(tail_ff[in_lvl]);
            count_ff[in_lvl] <= count_ff[in_lvl] + 1'b1;
            total_ff         <= total_ff + 1'b1;
         end
         if (cmd.pop) begin
            head_ff[top_lvl]  <= advance(head_ff[top_lvl]);
            count_ff[top_lvl] <= count_ff[top_lvl] - 1'b1;
            total_ff          <= total_ff - 1'b1;
         end
         if (cmd.respond) begin
            busy_ff <= 1'b0;
            if (cur_pool_ff) begin
               done_b_ff <= done_b_ff + 1'b1;
            end else begin
               done_a_ff <= done_a_ff + 1'b1;
            end
         end
         if (cmd.direct) begin
            busy_ff     <= 1'b1;
            cur_vm_ff   <= item_ff.vm_ident;
            cur_req_ff  <= item_ff.req_ident;
            cur_pool_ff <= item_ff.pool;
            cur_prio_ff <= item_ff.prio;
         end
         if (cmd.load) begin
            busy_ff     <= 1'b1;
            cur_vm_ff   <= rd_ff.vm;
            cur_req_ff  <= rd_ff.req;
            cur_pool_ff <= rd_ff.pool;
            cur_prio_ff <= PRIO_W'(sel_lvl_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reject) begin
         out_ff <= '{kind: KIND_REJECT, out_vm: item_ff.vm_ident,
                     out_req: item_ff.req_ident, out_pool: item_ff.pool,
                     out_prio: item_ff.prio, out_a: '0, out_b: '0,
                     out_value: '0, waiting: '0, done_pool_a: '0,
                     done_pool_b: '0, last: 1'b1};
      end else if (cmd.direct) begin
         out_ff <= '{kind: KIND_DISPATCH, out_vm: item_ff.vm_ident,
                     out_req: item_ff.req_ident, out_pool: item_ff.pool,
                     out_prio: item_ff.prio, out_a: item_ff.operand_a,
                     out_b: item_ff.operand_b, out_value: '0, waiting: '0,
                     done_pool_a: '0, done_pool_b: '0, last: 1'b1};
      end else if (cmd.respond) begin
         out_ff <= '{kind: KIND_RESPONSE, out_vm: cur_vm_ff,
                     out_req: cur_req_ff, out_pool: cur_pool_ff,
                     out_prio: cur_prio_ff, out_a: '0, out_b: '0,
                     out_value: item_ff.exec_result, waiting: '0,
                     done_pool_a: '0, done_pool_b: '0, last: !any_waiting};
      end else if (cmd.load) begin
         out_ff <= '{kind: KIND_DISPATCH, out_vm: rd_ff.vm, out_req: rd_ff.req,
                     out_pool: rd_ff.pool, out_prio: PRIO_W'(sel_lvl_ff),
                     out_a: rd_ff.a, out_b: rd_ff.b, out_value: '0,
                     waiting: '0, done_pool_a: '0, done_pool_b: '0,
                     last: 1'b1};
      end
   end

   // The queue state and counters are final for the whole transaction
   // sequence by the time any result is presented.
   always_comb begin
      rsp_payload             = out_ff;
      rsp_payload.waiting     = WAITING_W'(total_ff);
      rsp_payload.done_pool_a = done_a_ff;
      rsp_payload.done_pool_b = done_b_ff;
   end

endmodule

/* rtl/strict_priority_request_dispatcher.sv */
// Top level of the strict priority request dispatcher.
// Requests wait in one FIFO per priority level and are handed to a single
// executor slot, highest level first and oldest first within a level. A
// transaction is captured and then decided in the next cycle. Every result
// is held on the response channel until it is taken; a completion that
// releases a waiting request gives a response and then a dispatch, whose
// entry is read from the single-port entry store during the decision
// cycle. The entry store needs no clearing after reset.
module strict_priority_request_dispatcher #(
   parameter int LEVEL_DEPTH = spd_pkg::LEVEL_DEPTH_DEF,
   parameter int NUM_LEVELS  = spd_pkg::NUM_LEVELS_DEF
) (
   input logic        clock,
   input logic        reset,
   spd_chan_if.sink   req_bus,
   spd_chan_if.source rsp_bus
);
   import spd_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;
   rsp_item_type  rsp_item;

   spd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   spd_datapath #(
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .NUM_LEVELS  (NUM_LEVELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_bus.payload),
      .cmd         (ctrl_cmd),
      .status      (dp_status),
      .rsp_payload (rsp_item)
   );

   assign rsp_bus.payload = rsp_item;

   // An idle executor never leaves requests waiting once a sequence is done.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.payload.last |-> dp_status.busy || !dp_status.any_waiting)
      else $error("executor idle with requests waiting");

   // A result that is not the last one is always followed by a dispatch.
   a_mid_then_dispatch: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.payload.last
      |=> rsp_bus.valid && rsp_bus.payload.kind == KIND_DISPATCH)
      else $error("non-final result not followed by a dispatch");

   // No new transaction is taken while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request accepted while a result is pending");

endmodule
